### src/s2cd_pkg.sv
// Package for the seconds-to-calendar-date converter.
// Holds the time-of-day bundle, reciprocal constants and month-start tables.
// No dependencies.
package s2cd_pkg;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hr;
  } tod_t;

  typedef logic [8:0] doy_t;

  // Reciprocals for exact constant division over the value ranges of each stage.
  localparam logic [31:0] RECIP_60    = 32'h8888_8889;
  localparam logic [20:0] RECIP_24    = 21'd1398102;
  localparam logic [16:0] RECIP_CYCLE = 17'd91868;

  localparam logic [15:0] CYCLE_DAYS  = 16'd1461;

  localparam logic [10:0] YEAR1_START = 11'd366;
  localparam logic [10:0] YEAR2_START = 11'd731;
  localparam logic [10:0] YEAR3_START = 11'd1096;

  localparam doy_t MONTH_START_LEAP [12] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

  localparam doy_t MONTH_START_COMMON [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

endpackage

### src/s2cd_tod.sv
// Time-of-day front end: four pipeline stages of reciprocal division.
// Splits seconds, minutes and hours and forms the day count product.
// Depends on s2cd_pkg.
module s2cd_tod (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        epoch_seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output s2cd_pkg::tod_t     tod,
  output logic [15:0]        days,
  output logic [32:0]        days_prod
);

  logic        v1, v2, v3, v4;
  logic        rdy1, rdy2, rdy3, rdy4;

  logic [31:0] t1;
  logic [63:0] p1;

  logic [26:0] q1;
  logic [32:0] q1x60;
  logic [5:0]  sec2;
  logic [26:0] q1_2;
  logic [58:0] p2;

  logic [20:0] q2;
  logic [26:0] q2x60;
  logic [5:0]  sec3;
  logic [5:0]  min3;
  logic [20:0] q2_3;
  logic [41:0] p3;

  logic [15:0] q3;
  logic [19:0] q3x24;
  s2cd_pkg::tod_t tod4;
  logic [15:0] q3_4;
  logic [32:0] p4;

  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign q1    = p1[63:37];
  assign q1x60 = {q1, 6'b0} - {4'b0, q1, 2'b0};
  assign q2    = p2[57:37];
  assign q2x60 = {q2, 6'b0} - {4'b0, q2, 2'b0};
  assign q3    = p3[40:25];
  assign q3x24 = {q3, 4'b0} + {1'b0, q3, 3'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      t1 <= epoch_seconds;
      p1 <= 64'(epoch_seconds) * 64'(s2cd_pkg::RECIP_60);
    end
    if (rdy2) begin
      sec2 <= 6'(t1 - q1x60[31:0]);
      q1_2 <= q1;
      p2   <= 59'(q1) * 59'(s2cd_pkg::RECIP_60);
    end
    if (rdy3) begin
      sec3 <= sec2;
      min3 <= 6'(q1_2 - q2x60);
      q2_3 <= q2;
      p3   <= 42'(q2) * 42'(s2cd_pkg::RECIP_24);
    end
    if (rdy4) begin
      tod4.sec <= sec3;
      tod4.min <= min3;
      tod4.hr  <= 5'(q2_3 - 21'(q3x24));
      q3_4     <= q3;
      p4       <= 33'(q3) * 33'(s2cd_pkg::RECIP_CYCLE);
    end
  end

  assign out_valid = v4;
  assign tod       = tod4;
  assign days      = q3_4;
  assign days_prod = p4;

endmodule

### src/s2cd_cal.sv
// Calendar back end: three pipeline stages from day count to year, month, day.
// Splits four-year cycles, locates the year and then the month by table compare.
// Depends on s2cd_pkg.
module s2cd_cal (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  s2cd_pkg::tod_t     tod,
  input  logic [15:0]        days,
  input  logic [32:0]        days_prod,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         second_of_minute,
  output logic [5:0]         minute_of_hour,
  output logic [4:0]         hour_of_day,
  output logic [4:0]         day_of_month,
  output logic [3:0]         month_of_year,
  output logic [7:0]         years_since_2000
);

  logic           v5, v6, v7;
  logic           rdy5, rdy6, rdy7;

  logic [5:0]     cyc;
  logic [15:0]    cyc_days;
  s2cd_pkg::tod_t tod5;
  logic [5:0]     cyc5;
  logic [10:0]    dayin5;

  logic [1:0]     yr;
  logic [10:0]    year_base;
  s2cd_pkg::tod_t tod6;
  logic [5:0]     cyc6;
  logic [1:0]     yr6;
  logic [8:0]     doy6;

  logic [3:0]     mo;
  s2cd_pkg::doy_t mo_start;
  s2cd_pkg::tod_t tod7;
  logic [4:0]     day7;
  logic [3:0]     month7;
  logic [7:0]     years7;

  assign rdy7     = !v7 || out_ready;
  assign rdy6     = !v6 || rdy7;
  assign rdy5     = !v5 || rdy6;
  assign in_ready = rdy5;

  assign cyc      = days_prod[32:27];
  assign cyc_days = 16'(cyc) * s2cd_pkg::CYCLE_DAYS;

  always_comb begin
    if (dayin5 >= s2cd_pkg::YEAR3_START) begin
      yr        = 2'd3;
      year_base = s2cd_pkg::YEAR3_START;
    end else if (dayin5 >= s2cd_pkg::YEAR2_START) begin
      yr        = 2'd2;
      year_base = s2cd_pkg::YEAR2_START;
    end else if (dayin5 >= s2cd_pkg::YEAR1_START) begin
      yr        = 2'd1;
      year_base = s2cd_pkg::YEAR1_START;
    end else begin
      yr        = 2'd0;
      year_base = 11'd0;
    end
  end

  always_comb begin
    mo = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (yr6 == 2'd0) begin
        if (doy6 >= s2cd_pkg::MONTH_START_LEAP[i]) mo = 4'(i);
      end else begin
        if (doy6 >= s2cd_pkg::MONTH_START_COMMON[i]) mo = 4'(i);
      end
    end
    if (yr6 == 2'd0) begin
      mo_start = s2cd_pkg::MONTH_START_LEAP[mo];
    end else begin
      mo_start = s2cd_pkg::MONTH_START_COMMON[mo];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy5) v5 <= in_valid;
      if (rdy6) v6 <= v5;
      if (rdy7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      tod5   <= tod;
      cyc5   <= cyc;
      dayin5 <= 11'(days - cyc_days);
    end
    if (rdy6) begin
      tod6 <= tod5;
      cyc6 <= cyc5;
      yr6  <= yr;
      doy6 <= 9'(dayin5 - year_base);
    end
    if (rdy7) begin
      tod7   <= tod6;
      day7   <= 5'(doy6 - mo_start + 9'd1);
      month7 <= mo + 4'd1;
      years7 <= {cyc6, yr6};
    end
  end

  assign out_valid        = v7;
  assign second_of_minute = tod7.sec;
  assign minute_of_hour   = tod7.min;
  assign hour_of_day      = tod7.hr;
  assign day_of_month     = day7;
  assign month_of_year    = month7;
  assign years_since_2000 = years7;

endmodule

### src/seconds_to_calendar_date.sv
// Top level of the seconds-to-calendar-date converter.
// Chains the time-of-day front end and the calendar back end.
// Depends on s2cd_pkg, s2cd_tod and s2cd_cal.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    epoch_seconds
//   output    out_valid / out_ready  second_of_minute .. years_since_2000
//
// Each transfer in leaves as one transfer out after passing through the front-end and back-end stages.
// One transfer per cycle is sustained while the output is not stalled; the depth is set by four
// reciprocal multiply stages and three calendar table stages.
// Reset clears the valid bit of every stage; payload registers are not reset.
// Under a stall, a full stage holds until its successor can accept, and empty stages keep filling.
module seconds_to_calendar_date (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  second_of_minute,
  output logic [5:0]  minute_of_hour,
  output logic [4:0]  hour_of_day,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month_of_year,
  output logic [7:0]  years_since_2000
);

  logic           mid_valid;
  logic           mid_ready;
  s2cd_pkg::tod_t mid_tod;
  logic [15:0]    mid_days;
  logic [32:0]    mid_prod;

  s2cd_tod u_tod (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .epoch_seconds (epoch_seconds),
    .out_valid     (mid_valid),
    .out_ready     (mid_ready),
    .tod           (mid_tod),
    .days          (mid_days),
    .days_prod     (mid_prod)
  );

  s2cd_cal u_cal (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (mid_valid),
    .in_ready         (mid_ready),
    .tod              (mid_tod),
    .days             (mid_days),
    .days_prod        (mid_prod),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .second_of_minute (second_of_minute),
    .minute_of_hour   (minute_of_hour),
    .hour_of_day      (hour_of_day),
    .day_of_month     (day_of_month),
    .month_of_year    (month_of_year),
    .years_since_2000 (years_since_2000)
  );

endmodule
